// ===== hw/rtl/sap_pkg.sv =====
`default_nettype none
package sap_pkg;

  localparam int POS_BITS = 24;
  localparam int PORT_W = 24;
  localparam int CNT_W = 16;
  localparam int SUM_W = ((POS_BITS > PORT_W) ? POS_BITS : PORT_W) + 1;
  localparam longint POS_MAX_L = (longint'(1) << (POS_BITS - 1)) - 1;
  localparam logic signed [SUM_W-1:0] SUM_MAX = SUM_W'(POS_MAX_L);
  localparam logic signed [SUM_W-1:0] SUM_MIN = SUM_W'(-POS_MAX_L - 1);
  localparam logic signed [POS_BITS-1:0] POS_MAX = POS_BITS'(POS_MAX_L);
  localparam logic signed [POS_BITS-1:0] POS_MIN = POS_BITS'(-POS_MAX_L - 1);

  localparam logic [CNT_W-1:0] HALF_PERIOD_X_RST = 16'd100;
  localparam logic [CNT_W-1:0] HALF_PERIOD_Y_RST = 16'd200;
  localparam logic [CNT_W-1:0] SEARCH_LIMIT_RST = 16'd2000;
  localparam logic [CNT_W-1:0] BACKOFF_STEPS_RST = 16'd100;
  localparam logic [CNT_W-1:0] COUNT_SAT = '1;

  typedef enum logic [1:0] {
    FUNC_TICK   = 2'd0,
    FUNC_MOVE_X = 2'd1,
    FUNC_MOVE_Y = 2'd2,
    FUNC_HOME   = 2'd3
  } sap_func_t;

  typedef enum logic [1:0] {
    REG_HALF_PERIOD_X = 2'd0,
    REG_HALF_PERIOD_Y = 2'd1,
    REG_SEARCH_LIMIT  = 2'd2,
    REG_BACKOFF_STEPS = 2'd3
  } sap_reg_t;

  typedef enum logic [2:0] {
    PH_IDLE  = 3'd0,
    PH_X     = 3'd1,
    PH_YLOW  = 3'd2,
    PH_YHIGH = 3'd3,
    PH_BACK  = 3'd4
  } sap_phase_t;

  typedef enum logic [1:0] {
    STAT_NEVER    = 2'd0,
    STAT_HOMED    = 2'd1,
    STAT_Y_MISSED = 2'd2
  } sap_status_t;

  typedef struct packed {
    sap_func_t                 func;
    logic signed [PORT_W-1:0]  step_count;
    logic                      switch_x_pressed;
    logic                      switch_y_pressed;
  } sap_item_t;

  typedef struct packed {
    logic [CNT_W-1:0] half_period_x;
    logic [CNT_W-1:0] half_period_y;
    logic [CNT_W-1:0] search_limit;
    logic [CNT_W-1:0] backoff_steps;
  } sap_cfg_t;

  typedef struct packed {
    logic                      step_x;
    logic                      dir_x;
    logic                      step_y;
    logic                      dir_y;
    logic signed [PORT_W-1:0]  position_x;
    logic signed [PORT_W-1:0]  position_y;
    logic                      homing_busy;
    logic [1:0]                homing_status;
  } sap_result_t;

  function automatic logic signed [POS_BITS-1:0] clamp_pos(
    input logic signed [SUM_W-1:0] v
  );
    logic signed [POS_BITS-1:0] r;
    if (v > SUM_MAX) begin
      r = POS_MAX;
    end else if (v < SUM_MIN) begin
      r = POS_MIN;
    end else begin
      r = v[POS_BITS-1:0];
    end
    return r;
  endfunction

  function automatic logic signed [POS_BITS-1:0] step_pos(
    input logic signed [POS_BITS-1:0] p,
    input logic                       up
  );
    logic signed [POS_BITS-1:0] r;
    if (up) begin
      r = (p == POS_MAX) ? p : p + POS_BITS'(1);
    end else begin
      r = (p == POS_MIN) ? p : p - POS_BITS'(1);
    end
    return r;
  endfunction

  function automatic logic signed [PORT_W-1:0] to_port(
    input logic signed [POS_BITS-1:0] p
  );
    logic signed [SUM_W-1:0] e;
    e = SUM_W'(p);
    return e[PORT_W-1:0];
  endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/sap_in_reg.sv =====
`default_nettype none
module sap_in_reg (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire sap_pkg::sap_item_t item_in,
  input  wire logic              advance,
  output logic                   held_valid,
  output sap_pkg::sap_item_t     held_item
);
  import sap_pkg::*;

  assign in_ready = !held_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (in_ready) begin
      held_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      held_item <= item_in;
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/sap_cfg_regs.sv =====
`default_nettype none
module sap_cfg_regs (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      cfg_valid,
  output logic                           cfg_ready,
  input  wire logic [1:0]                cfg_index,
  input  wire logic [sap_pkg::CNT_W-1:0] cfg_data,
  output sap_pkg::sap_cfg_t              cfg
);
  import sap_pkg::*;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.half_period_x <= HALF_PERIOD_X_RST;
      cfg.half_period_y <= HALF_PERIOD_Y_RST;
      cfg.search_limit  <= SEARCH_LIMIT_RST;
      cfg.backoff_steps <= BACKOFF_STEPS_RST;
    end else if (cfg_valid) begin
      case (sap_reg_t'(cfg_index))
        REG_HALF_PERIOD_X: cfg.half_period_x <= cfg_data;
        REG_HALF_PERIOD_Y: cfg.half_period_y <= cfg_data;
        REG_SEARCH_LIMIT:  cfg.search_limit  <= cfg_data;
        REG_BACKOFF_STEPS: cfg.backoff_steps <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/sap_core.sv =====
`default_nettype none
module sap_core (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               advance,
  input  wire sap_pkg::sap_item_t item,
  input  wire sap_pkg::sap_cfg_t  cfg,
  output sap_pkg::sap_result_t    result
);
  import sap_pkg::*;

  sap_phase_t phase, phase_next;
  logic [CNT_W-1:0] tick_count_x, tick_count_x_next;
  logic [CNT_W-1:0] tick_count_y, tick_count_y_next;
  logic [CNT_W-1:0] search_count, search_count_next;
  logic [1:0] home_result, home_result_next;
  logic line_x, line_x_next, line_y, line_y_next;
  logic toggle_x, toggle_x_next, toggle_y, toggle_y_next;
  logic direction_x, direction_x_next, direction_y, direction_y_next;
  logic signed [POS_BITS-1:0] current_x, current_x_next, current_y, current_y_next;
  logic signed [POS_BITS-1:0] goal_x, goal_x_next, goal_y, goal_y_next;

  logic [CNT_W:0] tx_sum, ty_sum;
  logic ex, ey, busy, y_done, step_up;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_IDLE;
      tick_count_x <= '0;
      tick_count_y <= '0;
      search_count <= '0;
      home_result  <= STAT_NEVER;
      line_x       <= 1'b0;
      line_y       <= 1'b0;
      toggle_x     <= 1'b0;
      toggle_y     <= 1'b0;
      direction_x  <= 1'b0;
      direction_y  <= 1'b0;
      current_x    <= '0;
      current_y    <= '0;
      goal_x       <= '0;
      goal_y       <= '0;
    end else if (advance) begin
      phase        <= phase_next;
      tick_count_x <= tick_count_x_next;
      tick_count_y <= tick_count_y_next;
      search_count <= search_count_next;
      home_result  <= home_result_next;
      line_x       <= line_x_next;
      line_y       <= line_y_next;
      toggle_x     <= toggle_x_next;
      toggle_y     <= toggle_y_next;
      direction_x  <= direction_x_next;
      direction_y  <= direction_y_next;
      current_x    <= current_x_next;
      current_y    <= current_y_next;
      goal_x       <= goal_x_next;
      goal_y       <= goal_y_next;
    end
  end

  always_comb begin
    phase_next        = phase;
    tick_count_x_next = tick_count_x;
    tick_count_y_next = tick_count_y;
    search_count_next = search_count;
    home_result_next  = home_result;
    line_x_next       = line_x;
    line_y_next       = line_y;
    toggle_x_next     = toggle_x;
    toggle_y_next     = toggle_y;
    direction_x_next  = direction_x;
    direction_y_next  = direction_y;
    current_x_next    = current_x;
    current_y_next    = current_y;
    goal_x_next       = goal_x;
    goal_y_next       = goal_y;
    y_done            = 1'b0;

    tx_sum = {1'b0, tick_count_x} + (CNT_W+1)'(1);
    ty_sum = {1'b0, tick_count_y} + (CNT_W+1)'(1);
    ex = tx_sum >= {1'b0, cfg.half_period_x};
    ey = ty_sum >= {1'b0, cfg.half_period_y};
    busy = phase != PH_IDLE;
    step_up = (item.step_count != '0) && !item.step_count[PORT_W-1];

    case (item.func)
      FUNC_TICK: begin
        tick_count_x_next = ex ? '0 : tx_sum[CNT_W-1:0];
        tick_count_y_next = ey ? '0 : ty_sum[CNT_W-1:0];
        if (busy) begin
          if (phase == PH_X) begin
            if (ex) begin
              if (line_x) begin
                line_x_next = 1'b0;
              end else if (item.switch_x_pressed) begin
                current_x_next    = '0;
                goal_x_next       = '0;
                phase_next        = PH_YLOW;
                direction_y_next  = 1'b0;
                search_count_next = '0;
              end else begin
                line_x_next = 1'b1;
              end
            end
          end else if (ey) begin
            if (line_y) begin
              line_y_next = 1'b0;
            end else begin
              case (phase)
                PH_YLOW: begin
                  if (item.switch_y_pressed) begin
                    current_y_next   = '0;
                    goal_y_next      = '0;
                    home_result_next = STAT_HOMED;
                    phase_next       = PH_IDLE;
                    y_done           = 1'b1;
                  end else if (search_count >= cfg.search_limit) begin
                    phase_next        = PH_YHIGH;
                    direction_y_next  = 1'b1;
                    search_count_next = '0;
                    y_done            = 1'b1;
                  end
                end
                PH_YHIGH: begin
                  if (item.switch_y_pressed) begin
                    phase_next        = PH_BACK;
                    search_count_next = '0;
                  end else if (search_count >= cfg.search_limit) begin
                    goal_y_next      = current_y;
                    home_result_next = STAT_Y_MISSED;
                    phase_next       = PH_IDLE;
                    y_done           = 1'b1;
                  end
                end
                default: ;
              endcase
              if (!y_done && phase_next == PH_BACK &&
                  search_count_next >= cfg.backoff_steps) begin
                current_y_next   = '0;
                goal_y_next      = '0;
                home_result_next = STAT_HOMED;
                phase_next       = PH_IDLE;
                y_done           = 1'b1;
              end
              if (!y_done) begin
                line_y_next = 1'b1;
                if (search_count_next != COUNT_SAT) begin
                  search_count_next = search_count_next + CNT_W'(1);
                end
              end
            end
          end
        end else begin
          // A position count is taken on each write of a high step level.
          if (ex && current_x != goal_x) begin
            line_x_next   = toggle_x;
            toggle_x_next = !toggle_x;
            if (toggle_x) begin
              current_x_next = step_pos(current_x, direction_x);
            end
          end
          if (ey && current_y != goal_y) begin
            line_y_next   = toggle_y;
            toggle_y_next = !toggle_y;
            if (toggle_y) begin
              current_y_next = step_pos(current_y, direction_y);
            end
          end
        end
      end
      FUNC_MOVE_X: begin
        if (!busy) begin
          direction_x_next = step_up;
          goal_x_next = clamp_pos(SUM_W'(current_x) + SUM_W'(item.step_count));
        end
      end
      FUNC_MOVE_Y: begin
        if (!busy) begin
          direction_y_next = step_up;
          goal_y_next = clamp_pos(SUM_W'(current_y) + SUM_W'(item.step_count));
        end
      end
      FUNC_HOME: begin
        if (!busy) begin
          phase_next        = PH_X;
          direction_x_next  = 1'b0;
          search_count_next = '0;
        end
      end
      default: ;
    endcase

    result.step_x        = line_x_next;
    result.dir_x         = direction_x_next;
    result.step_y        = line_y_next;
    result.dir_y         = direction_y_next;
    result.position_x    = to_port(current_x_next);
    result.position_y    = to_port(current_y_next);
    result.homing_busy   = phase_next != PH_IDLE;
    result.homing_status = home_result_next;
  end

endmodule
`default_nettype wire

// ===== hw/rtl/sap_out_reg.sv =====
`default_nettype none
module sap_out_reg (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 advance,
  input  wire sap_pkg::sap_result_t result_in,
  input  wire logic                 out_ready,
  output logic                      out_valid,
  output sap_pkg::sap_result_t      result
);
  import sap_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      result <= result_in;
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/stepper_axis_pair_with_homing_unit.sv =====
// A word accepted into the input register passes through the state update into the result register.
// Throughput: one word per cycle; the input register and the state update both
// move in the same cycle whenever the result register is empty or being taken.
// Reset clears all axis, homing and handshake state; the four configuration
// registers return to 100, 200, 2000 and 100.
`default_nettype none
module stepper_axis_pair_with_homing_unit (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         in_valid,
  output logic                              in_ready,
  input  wire logic [1:0]                   func,
  input  wire logic signed [23:0]           step_count,
  input  wire logic                         switch_x_pressed,
  input  wire logic                         switch_y_pressed,
  output logic                              out_valid,
  input  wire logic                         out_ready,
  output logic                              step_x,
  output logic                              dir_x,
  output logic                              step_y,
  output logic                              dir_y,
  output logic signed [23:0]                position_x,
  output logic signed [23:0]                position_y,
  output logic                              homing_busy,
  output logic [1:0]                        homing_status,
  input  wire logic                         cfg_valid,
  output logic                              cfg_ready,
  input  wire logic [1:0]                   cfg_index,
  input  wire logic [sap_pkg::CNT_W-1:0]    cfg_data
);
  import sap_pkg::*;

  sap_item_t   item_in, held_item;
  sap_cfg_t    cfg;
  sap_result_t result_next, result;
  logic        held_valid, advance;

  assign item_in.func             = sap_func_t'(func);
  assign item_in.step_count       = step_count;
  assign item_in.switch_x_pressed = switch_x_pressed;
  assign item_in.switch_y_pressed = switch_y_pressed;

  assign advance = held_valid && (!out_valid || out_ready);

  sap_in_reg u_in_reg (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .item_in    (item_in),
    .advance    (advance),
    .held_valid (held_valid),
    .held_item  (held_item)
  );

  sap_cfg_regs u_cfg_regs (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  sap_core u_core (
    .clk     (clk),
    .rst     (rst),
    .advance (advance),
    .item    (held_item),
    .cfg     (cfg),
    .result  (result_next)
  );

  sap_out_reg u_out_reg (
    .clk       (clk),
    .rst       (rst),
    .advance   (advance),
    .result_in (result_next),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .result    (result)
  );

  assign step_x        = result.step_x;
  assign dir_x         = result.dir_x;
  assign step_y        = result.step_y;
  assign dir_y         = result.dir_y;
  assign position_x    = result.position_x;
  assign position_y    = result.position_y;
  assign homing_busy   = result.homing_busy;
  assign homing_status = result.homing_status;

endmodule
`default_nettype wire

// ===== hw/rtl/sap_checker.sv =====
`default_nettype none
module sap_checker (
  input wire logic              clk,
  input wire logic              rst,
  input wire logic              in_valid,
  input wire logic              in_ready,
  input wire logic              out_valid,
  input wire logic              out_ready,
  input wire logic signed [23:0] position_x,
  input wire logic [1:0]        homing_status
);

  // A stalled result word keeps its contents.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(position_x) && $stable(homing_status))
    else $error("result word changed while stalled");

  // The homing status only ever takes its three defined codes.
  a_status_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> homing_status != 2'd3)
    else $error("undefined homing status");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result word present after reset");

  // With the result register empty nothing can hold the input back.
  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input stalled with empty result register");

endmodule

bind stepper_axis_pair_with_homing_unit sap_checker u_sap_checker (.*);
`default_nettype wire

// ===== test/stepper_axis_pair_with_homing_unit_tb.sv =====
module stepper_axis_pair_with_homing_unit_tb;
  import sap_pkg::*;

  localparam longint POS_TOP = (longint'(1) << 23) - 1;
  localparam longint POS_BOT = -POS_TOP - 1;
  localparam int WORD_GOAL = 1050;

  typedef struct packed {
    logic [15:0] cnt;
    logic        lvl;
    logic        tog;
    logic        up;
    logic [23:0] pos;
    logic [23:0] tgt;
  } axis_t;

  typedef struct packed {
    logic        is_reg;
    sap_reg_t    idx;
    logic [15:0] data;
    sap_func_t   f;
    logic [23:0] sc;
    logic        sx;
    logic        sy;
    logic        typed;
    sap_result_t res;
  } plan_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  sap_func_t func = FUNC_TICK;
  logic signed [23:0] step_count = '0;
  logic switch_x_pressed = 1'b0;
  logic switch_y_pressed = 1'b0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic step_x, dir_x, step_y, dir_y;
  logic signed [23:0] position_x, position_y;
  logic homing_busy;
  logic [1:0] homing_status;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  sap_reg_t cfg_index = REG_HALF_PERIOD_X;
  logic [CNT_W-1:0] cfg_data = '0;

  logic typed_on = 1'b0;
  sap_result_t typed_res = '0;

  logic [15:0] per_x = HALF_PERIOD_X_RST;
  logic [15:0] per_y = HALF_PERIOD_Y_RST;
  logic [15:0] hunt_limit = SEARCH_LIMIT_RST;
  logic [15:0] back_limit = BACKOFF_STEPS_RST;
  axis_t ax_x = '0;
  axis_t ax_y = '0;
  sap_phase_t home_stage = PH_IDLE;
  sap_status_t home_state = STAT_NEVER;
  logic [15:0] hunt_count = '0;

  sap_result_t expected_words[$];
  plan_t plan[$];
  int mismatches = 0;
  int live_items = 0;
  logic idle_on = 1'b1;
  logic stall_on = 1'b1;
  logic long_hold = 1'b0;

  stepper_axis_pair_with_homing_unit i_dut (.*);

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic logic [23:0] clip_pos(input longint v);
    if (v > POS_TOP) begin
      return 24'(POS_TOP);
    end
    if (v < POS_BOT) begin
      return 24'(POS_BOT);
    end
    return 24'(v);
  endfunction

  function automatic axis_t run_axis(input axis_t a);
    if (a.pos != a.tgt) begin
      a.lvl = a.tog;
      a.tog = ~a.tog;
      if (!a.tog) begin
        a.pos = clip_pos(longint'($signed(a.pos)) + (a.up ? 1 : -1));
      end
    end
    return a;
  endfunction

  function automatic axis_t aim_axis(input axis_t a, input logic signed [23:0] sc);
    a.up = (sc > 0);
    a.tgt = clip_pos(longint'($signed(a.pos)) + longint'(sc));
    return a;
  endfunction

  function automatic void home_x(input logic sw);
    if (ax_x.lvl) begin
      ax_x.lvl = 1'b0;
    end else if (sw) begin
      ax_x.pos = '0;
      ax_x.tgt = '0;
      home_stage = PH_YLOW;
      ax_y.up = 1'b0;
      hunt_count = '0;
    end else begin
      ax_x.lvl = 1'b1;
    end
  endfunction

  function automatic void zero_y();
    ax_y.pos = '0;
    ax_y.tgt = '0;
    home_state = STAT_HOMED;
    home_stage = PH_IDLE;
  endfunction

  function automatic void home_y(input logic sw);
    if (ax_y.lvl) begin
      ax_y.lvl = 1'b0;
      return;
    end
    if (home_stage == PH_YLOW) begin
      if (sw) begin
        zero_y();
        return;
      end
      if (hunt_count >= hunt_limit) begin
        home_stage = PH_YHIGH;
        ax_y.up = 1'b1;
        hunt_count = '0;
        return;
      end
    end else if (home_stage == PH_YHIGH) begin
      if (sw) begin
        home_stage = PH_BACK;
        hunt_count = '0;
      end else if (hunt_count >= hunt_limit) begin
        ax_y.tgt = ax_y.pos;
        home_state = STAT_Y_MISSED;
        home_stage = PH_IDLE;
        return;
      end
    end
    if (home_stage == PH_BACK && hunt_count >= back_limit) begin
      zero_y();
      return;
    end
    ax_y.lvl = 1'b1;
    if (hunt_count != 16'hFFFF) begin
      hunt_count = hunt_count + 16'd1;
    end
  endfunction

  task automatic step_axes(input sap_func_t f, input logic signed [23:0] sc,
                           input logic sx, input logic sy, output sap_result_t r);
    logic busy, ev_x, ev_y;
    busy = (home_stage != PH_IDLE);
    case (f)
      FUNC_TICK: begin
        ev_x = (32'(ax_x.cnt) + 1 >= 32'(per_x));
        ax_x.cnt = ev_x ? 16'd0 : ax_x.cnt + 16'd1;
        ev_y = (32'(ax_y.cnt) + 1 >= 32'(per_y));
        ax_y.cnt = ev_y ? 16'd0 : ax_y.cnt + 16'd1;
        if (busy) begin
          if (home_stage == PH_X) begin
            if (ev_x) begin
              home_x(sx);
            end
          end else if (ev_y) begin
            home_y(sy);
          end
        end else begin
          if (ev_x) begin
            ax_x = run_axis(ax_x);
          end
          if (ev_y) begin
            ax_y = run_axis(ax_y);
          end
        end
      end
      FUNC_MOVE_X: begin
        if (!busy) begin
          ax_x = aim_axis(ax_x, sc);
        end
      end
      FUNC_MOVE_Y: begin
        if (!busy) begin
          ax_y = aim_axis(ax_y, sc);
        end
      end
      default: begin
        if (!busy) begin
          home_stage = PH_X;
          ax_x.up = 1'b0;
          hunt_count = '0;
        end
      end
    endcase
    r.step_x = ax_x.lvl;
    r.dir_x = ax_x.up;
    r.step_y = ax_y.lvl;
    r.dir_y = ax_y.up;
    r.position_x = ax_x.pos;
    r.position_y = ax_y.pos;
    r.homing_busy = (home_stage != PH_IDLE);
    r.homing_status = home_state;
  endtask

  function automatic void store_setting(input sap_reg_t idx, input logic [15:0] d);
    case (idx)
      REG_HALF_PERIOD_X: per_x = d;
      REG_HALF_PERIOD_Y: per_y = d;
      REG_SEARCH_LIMIT:  hunt_limit = d;
      default:           back_limit = d;
    endcase
  endfunction

  function automatic void cmp_field(input string name, input logic signed [63:0] e,
                                    input logic signed [63:0] a);
    if (a !== e) begin
      $error("%s: expected %0d, got %0d", name, e, a);
      mismatches++;
    end
  endfunction

  function automatic void check_word(input sap_result_t e);
    cmp_field("step_x", e.step_x, step_x);
    cmp_field("dir_x", e.dir_x, dir_x);
    cmp_field("step_y", e.step_y, step_y);
    cmp_field("dir_y", e.dir_y, dir_y);
    cmp_field("position_x", e.position_x, position_x);
    cmp_field("position_y", e.position_y, position_y);
    cmp_field("homing_busy", e.homing_busy, homing_busy);
    cmp_field("homing_status", e.homing_status, homing_status);
  endfunction

  always @(posedge clk) begin
    sap_result_t want;
    if (!rst) begin
      if (out_valid && out_ready) begin
        if (expected_words.size() == 0) begin
          $error("result word with nothing expected");
          mismatches++;
        end else begin
          check_word(expected_words.pop_front());
        end
      end
      if (cfg_valid && cfg_ready) begin
        store_setting(cfg_index, cfg_data);
      end
      if (in_valid && in_ready) begin
        live_items++;
        step_axes(func, step_count, switch_x_pressed, switch_y_pressed, want);
        expected_words.push_back(typed_on ? typed_res : want);
      end
    end
  end

  initial begin
    forever begin
      @(negedge clk);
      if (long_hold) begin
        out_ready <= 1'b0;
        repeat (80) @(negedge clk);
        long_hold = 1'b0;
        out_ready <= 1'b1;
      end else if (stall_on && $urandom_range(0, 7) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 18)) @(negedge clk);
        out_ready <= 1'b1;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  task automatic send_word(input sap_func_t f, input logic [23:0] sc, input logic sx,
                           input logic sy, input logic chk, input sap_result_t res);
    @(negedge clk);
    if (idle_on && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(negedge clk);
    end
    in_valid <= 1'b1;
    func <= f;
    step_count <= sc;
    switch_x_pressed <= sx;
    switch_y_pressed <= sy;
    typed_on <= chk;
    typed_res <= res;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic set_reg(input sap_reg_t idx, input logic [15:0] d);
    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= d;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic load_regs(input logic [15:0] hx, input logic [15:0] hy,
                           input logic [15:0] sl, input logic [15:0] bo);
    set_reg(REG_HALF_PERIOD_X, hx);
    set_reg(REG_HALF_PERIOD_Y, hy);
    set_reg(REG_SEARCH_LIMIT, sl);
    set_reg(REG_BACKOFF_STEPS, bo);
  endtask

  function automatic sap_result_t rest_word(input logic dx, input logic dy);
    sap_result_t r;
    r = '0;
    r.dir_x = dx;
    r.dir_y = dy;
    return r;
  endfunction

  function automatic plan_t word_row(input sap_func_t f, input logic [23:0] sc,
                                     input logic sx, input logic sy, input logic typed,
                                     input sap_result_t res);
    plan_t p;
    p = '0;
    p.f = f;
    p.sc = sc;
    p.sx = sx;
    p.sy = sy;
    p.typed = typed;
    p.res = res;
    return p;
  endfunction

  function automatic plan_t reg_row(input sap_reg_t idx, input logic [15:0] d);
    plan_t p;
    p = '0;
    p.is_reg = 1'b1;
    p.idx = idx;
    p.data = d;
    return p;
  endfunction

  initial begin
    int stage, words, swx_pct, swy_pct, pick;
    logic [23:0] sc;
    sap_func_t f;

    plan.push_back(word_row(FUNC_TICK, 24'h000000, 1'b0, 1'b0, 1'b1, rest_word(1'b0, 1'b0)));
    plan.push_back(word_row(FUNC_MOVE_X, 24'h7FFFFF, 1'b0, 1'b0, 1'b1, rest_word(1'b1, 1'b0)));
    plan.push_back(word_row(FUNC_MOVE_Y, 24'h800000, 1'b0, 1'b0, 1'b1, rest_word(1'b1, 1'b0)));
    plan.push_back(word_row(FUNC_MOVE_X, 24'h000000, 1'b0, 1'b0, 1'b1, rest_word(1'b0, 1'b0)));
    plan.push_back(word_row(FUNC_TICK, 24'hFFFFFF, 1'b1, 1'b1, 1'b1, rest_word(1'b0, 1'b0)));
    // A half period of zero makes every tick a step event.
    plan.push_back(reg_row(REG_HALF_PERIOD_X, 16'd0));
    plan.push_back(reg_row(REG_HALF_PERIOD_Y, 16'd0));
    plan.push_back(word_row(FUNC_MOVE_X, 24'hFFFFFF, 1'b0, 1'b0, 1'b0, '0));
    plan.push_back(word_row(FUNC_MOVE_Y, 24'h000005, 1'b0, 1'b0, 1'b0, '0));
    repeat (3) plan.push_back(word_row(FUNC_TICK, 24'h0, 1'b0, 1'b0, 1'b0, '0));
    // Both goals saturate at the ends of the position range.
    plan.push_back(word_row(FUNC_MOVE_X, 24'h800000, 1'b0, 1'b0, 1'b0, '0));
    plan.push_back(word_row(FUNC_MOVE_Y, 24'h7FFFFF, 1'b0, 1'b0, 1'b0, '0));
    plan.push_back(reg_row(REG_SEARCH_LIMIT, 16'd1));
    plan.push_back(reg_row(REG_BACKOFF_STEPS, 16'd2));
    plan.push_back(word_row(FUNC_HOME, 24'h0, 1'b0, 1'b0, 1'b0, '0));
    plan.push_back(word_row(FUNC_MOVE_X, 24'h000007, 1'b0, 1'b0, 1'b0, '0));
    plan.push_back(word_row(FUNC_HOME, 24'h0, 1'b0, 1'b0, 1'b0, '0));
    repeat (2) plan.push_back(word_row(FUNC_TICK, 24'h0, 1'b0, 1'b0, 1'b0, '0));
    // The first pressed tick meets a high step line and must not end the X search.
    repeat (2) plan.push_back(word_row(FUNC_TICK, 24'h0, 1'b1, 1'b0, 1'b0, '0));
    // With the Y switch never closing, both search directions run out.
    repeat (8) plan.push_back(word_row(FUNC_TICK, 24'h0, 1'b0, 1'b0, 1'b0, '0));

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (plan[i]) begin
      if (plan[i].is_reg) begin
        set_reg(plan[i].idx, plan[i].data);
      end else begin
        send_word(plan[i].f, plan[i].sc, plan[i].sx, plan[i].sy, plan[i].typed, plan[i].res);
      end
    end

    stage = 0;
    while (live_items < WORD_GOAL) begin
      if (stage == 0) begin
        load_regs(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
      end else if (stage == 1) begin
        load_regs(16'd0, 16'd1, 16'd0, 16'd0);
      end else begin
        load_regs(16'($urandom_range(0, 9) == 0 ? $urandom_range(4, 40) : $urandom_range(0, 3)),
                  16'($urandom_range(0, 9) == 0 ? $urandom_range(4, 40) : $urandom_range(0, 3)),
                  16'($urandom_range(0, 6)), 16'($urandom_range(0, 6)));
      end
      if (live_items >= WORD_GOAL - 150) begin
        idle_on = 1'b0;
        stall_on = 1'b0;
      end else begin
        idle_on = ($urandom_range(0, 3) != 0);
        stall_on = ($urandom_range(0, 3) != 0);
      end
      if (stage == 3) begin
        long_hold = 1'b1;
      end
      swx_pct = $urandom_range(0, 1) ? 15 : 45;
      case ($urandom_range(0, 2))
        0:       swy_pct = 0;
        1:       swy_pct = 20;
        default: swy_pct = 60;
      endcase
      words = $urandom_range(30, 80);
      repeat (words) begin
        pick = $urandom_range(0, 99);
        if (pick < 70) begin
          f = FUNC_TICK;
        end else if (pick < 80) begin
          f = FUNC_MOVE_X;
        end else if (pick < 90) begin
          f = FUNC_MOVE_Y;
        end else begin
          f = FUNC_HOME;
        end
        case ($urandom_range(0, 9))
          0: begin
            case ($urandom_range(0, 3))
              0:       sc = 24'h7FFFFF;
              1:       sc = 24'h800000;
              2:       sc = 24'h000000;
              default: sc = 24'hFFFFFF;
            endcase
          end
          1:       sc = 24'($urandom);
          default: sc = 24'($urandom_range(0, 24)) - 24'd12;
        endcase
        send_word(f, sc, $urandom_range(0, 99) < swx_pct, $urandom_range(0, 99) < swy_pct,
                  1'b0, '0);
      end
      stage++;
    end

    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (mismatches == 0) begin
      $display("stepper_axis_pair_with_homing_unit regression: pass");
    end else begin
      $display("stepper_axis_pair_with_homing_unit regression: fail");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("stepper_axis_pair_with_homing_unit regression: fail");
    $finish;
  end

endmodule
